[design/imra_pkg.sv]
`default_nettype none

package imra_pkg;

    // command codes carried on s_axis_tuser
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    // bus sequencer steps, one-hot
    typedef enum logic [14:0] {
        ST_IDLE = 15'h0001,
        ST_ST1  = 15'h0002,
        ST_ST2  = 15'h0004,
        ST_ST3  = 15'h0008,
        ST_TXH  = 15'h0010,
        ST_TXL  = 15'h0020,
        ST_AKH  = 15'h0040,
        ST_AKL  = 15'h0080,
        ST_RXH  = 15'h0100,
        ST_RXL  = 15'h0200,
        ST_MAH  = 15'h0400,
        ST_MAL  = 15'h0800,
        ST_SP1  = 15'h1000,
        ST_SP2  = 15'h2000,
        ST_SP3  = 15'h4000
    } t_step;

    localparam int unsigned BITS_PER_BYTE = 4'd8;

    // result beat, highest field first in m_axis_tdata
    typedef struct packed {
        logic       pad;
        logic       success;
        logic       done_res;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       busy_res;
        logic       sda_drive;
        logic       sda_out;
        logic       scl;
    } t_result;

    // input beat payload, highest field first in s_axis_tdata
    typedef struct packed {
        logic [1:0] pad;
        logic       sda_in;
        logic [4:0] byte_count;
        logic [7:0] write_byte;
        logic [7:0] register_byte_in;
        logic [7:0] device_byte_in;
    } t_item;

endpackage

`default_nettype wire

[design/imra_wbuf.sv]
`default_nettype none

module imra_wbuf
    import imra_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [7:0]         o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/i2c_master_register_access.sv]
`default_nettype none
// The result beat of an accepted input beat is registered and shown in the cycle after it.
// Throughput: one beat per cycle while m_axis_tready holds; the sequencer takes one step per tick beat.
// Input is taken whenever the result register is empty or being drained.
// Write-buffer data is prefetched one byte ahead from a registered-read RAM.
// Reset (synchronous, active low) idles the sequencer and empties the result register;
// the write buffer is not cleared.

module i2c_master_register_access
    import imra_pkg::*;
#(
    parameter int BUFFER_BYTES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] device_byte_in, [15:8] register_byte_in, [23:16] write_byte,
    // [28:24] byte_count, [29] sda_in, [31:30] zero
    input  wire logic [31:0] s_axis_tdata,
    // [1:0] cmd
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] scl, [1] sda_out, [2] sda_drive, [3] busy_res, [11:4] read_byte,
    // [12] read_valid, [13] done_res, [14] success, [15] zero
    output logic [15:0]      m_axis_tdata
);

    localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int LW = $clog2(BUFFER_BYTES + 1);
    localparam int IW = $clog2(BUFFER_BYTES + 3);

    t_item   w_item;
    t_cmd    w_cmd;
    logic    w_accept;
    logic    w_busy;

    t_step          r_step,     n_step;
    logic [3:0]     r_bit_cnt,  n_bit_cnt;
    logic [IW-1:0]  r_byte_idx, n_byte_idx;
    logic [7:0]     r_shift,    n_shift;
    logic [LW-1:0]  r_load_ptr, n_load_ptr;
    logic [7:0]     r_dev,      n_dev;
    logic [7:0]     r_reg,      n_reg;
    logic [IW-1:0]  r_xfer_cnt, n_xfer_cnt;
    logic           r_reading,  n_reading;
    logic           r_failed,   n_failed;
    logic           r_out_valid;
    t_result        r_out,      n_out;

    logic           w_we;
    logic [7:0]     w_buf_rdata;
    logic [7:0]     w_send_byte;
    logic           w_begin;
    logic           w_nack;
    logic [IW:0]    w_idx_inc;

    assign w_item   = t_item'(s_axis_tdata);
    assign w_cmd    = t_cmd'(s_axis_tuser);
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_busy   = (r_step != ST_IDLE);

    // prefetch: the byte after the current one is entry byte_index - 1
    imra_wbuf #(
        .DEPTH (BUFFER_BYTES),
        .AW    (AW)
    ) u_wbuf (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_we),
        .i_waddr (r_load_ptr[AW-1:0]),
        .i_wdata (w_item.write_byte),
        .i_raddr (AW'(r_byte_idx - IW'(1))),
        .o_rdata (w_buf_rdata)
    );

    always_comb begin
        n_step     = r_step;
        n_bit_cnt  = r_bit_cnt;
        n_byte_idx = r_byte_idx;
        n_shift    = r_shift;
        n_load_ptr = r_load_ptr;
        n_dev      = r_dev;
        n_reg      = r_reg;
        n_xfer_cnt = r_xfer_cnt;
        n_reading  = r_reading;
        n_failed   = r_failed;
        w_we       = 1'b0;
        w_begin    = 1'b0;
        w_idx_inc  = {1'b0, r_byte_idx} + (IW+1)'(1);
        n_out      = '0;

        case (w_cmd)
            CMD_LOAD: begin
                if (!w_busy && r_load_ptr < LW'(BUFFER_BYTES)) begin
                    w_we       = 1'b1;
                    n_load_ptr = r_load_ptr + LW'(1);
                end
            end
            CMD_WRITE, CMD_READ: begin
                if (!w_busy) begin
                    n_dev      = w_item.device_byte_in;
                    n_reg      = w_item.register_byte_in;
                    n_xfer_cnt = (32'(w_item.byte_count) > BUFFER_BYTES) ?
                                 IW'(BUFFER_BYTES) : IW'(w_item.byte_count);
                    n_reading  = (w_cmd == CMD_READ);
                    if (w_cmd == CMD_WRITE) begin
                        n_load_ptr = '0;
                    end
                    n_failed   = 1'b0;
                    n_byte_idx = '0;
                    n_bit_cnt  = '0;
                    n_step     = ST_ST1;
                end
            end
            default: begin
                case (r_step)
                    ST_ST1: n_step = ST_ST2;
                    ST_ST2: n_step = ST_ST3;
                    ST_ST3: w_begin = 1'b1;
                    ST_TXH: n_step = ST_TXL;
                    ST_TXL: begin
                        n_shift   = {r_shift[6:0], 1'b0};
                        n_bit_cnt = r_bit_cnt + 4'd1;
                        n_step    = (n_bit_cnt >= 4'(BITS_PER_BYTE)) ? ST_AKH : ST_TXH;
                    end
                    ST_AKH: begin
                        if (w_item.sda_in) begin
                            n_failed = 1'b1;
                        end
                        n_step = ST_AKL;
                    end
                    ST_AKL: begin
                        if (r_failed) begin
                            n_step = ST_SP1;
                        end else begin
                            n_byte_idx = w_idx_inc[IW-1:0];
                            if (!r_reading) begin
                                if (w_idx_inc < (IW+1)'(2) + {1'b0, r_xfer_cnt}) begin
                                    w_begin = 1'b1;
                                end else begin
                                    n_step = ST_SP1;
                                end
                            end else if (w_idx_inc == (IW+1)'(1)) begin
                                w_begin = 1'b1;
                            end else if (w_idx_inc == (IW+1)'(2)) begin
                                // repeated start before the read-direction device byte
                                n_step = ST_ST1;
                            end else begin
                                n_byte_idx = '0;
                                n_bit_cnt  = '0;
                                n_shift    = '0;
                                n_step     = (r_xfer_cnt == '0) ? ST_SP1 : ST_RXH;
                            end
                        end
                    end
                    ST_RXH: begin
                        n_shift   = {r_shift[6:0], w_item.sda_in};
                        n_bit_cnt = r_bit_cnt + 4'd1;
                        if (n_bit_cnt >= 4'(BITS_PER_BYTE)) begin
                            n_out.read_valid = 1'b1;
                            n_out.read_byte  = n_shift;
                        end
                        n_step = ST_RXL;
                    end
                    ST_RXL: n_step = (r_bit_cnt >= 4'(BITS_PER_BYTE)) ? ST_MAH : ST_RXH;
                    ST_MAH: n_step = ST_MAL;
                    ST_MAL: begin
                        n_byte_idx = w_idx_inc[IW-1:0];
                        if (w_idx_inc < {1'b0, r_xfer_cnt}) begin
                            n_bit_cnt = '0;
                            n_shift   = '0;
                            n_step    = ST_RXH;
                        end else begin
                            n_step = ST_SP1;
                        end
                    end
                    ST_SP1: n_step = ST_SP2;
                    ST_SP2: n_step = ST_SP3;
                    ST_SP3: begin
                        n_step         = ST_IDLE;
                        n_out.done_res = 1'b1;
                        n_out.success  = !r_failed;
                    end
                    default: n_step = ST_IDLE;
                endcase
            end
        endcase

        // load the next byte to shift out
        if (n_byte_idx == '0) begin
            w_send_byte = r_dev;
        end else if (n_byte_idx == IW'(1)) begin
            w_send_byte = r_reg;
        end else if (r_reading) begin
            w_send_byte = {r_dev[7:1], 1'b1};
        end else begin
            w_send_byte = w_buf_rdata;
        end
        if (w_begin) begin
            n_shift   = w_send_byte;
            n_bit_cnt = '0;
            n_step    = ST_TXH;
        end

        w_nack = ({1'b0, n_byte_idx} + (IW+1)'(1)) >= {1'b0, n_xfer_cnt};

        // pin levels for the coming phase: scl, sda, drive
        case (n_step)
            ST_ST1: {n_out.scl, n_out.sda_out, n_out.sda_drive} = 3'b111;
            ST_ST2: {n_out.scl, n_out.sda_out, n_out.sda_drive} = 3'b101;
            ST_ST3: {n_out.scl, n_out.sda_out, n_out.sda_drive} = 3'b001;
            ST_TXH: {n_out.scl, n_out.sda_out, n_out.sda_drive} = {1'b1, n_shift[7], 1'b1};
            ST_TXL: {n_out.scl, n_out.sda_out, n_out.sda_drive} = {1'b0, n_shift[7], 1'b1};
            ST_AKH: {n_out.scl, n_out.sda_out, n_out.sda_drive} = 3'b110;
            ST_AKL: {n_out.scl, n_out.sda_out, n_out.sda_drive} = 3'b011;
            ST_RXH: {n_out.scl, n_out.sda_out, n_out.sda_drive} = 3'b110;
            ST_RXL: {n_out.scl, n_out.sda_out, n_out.sda_drive} = 3'b010;
            ST_MAH: {n_out.scl, n_out.sda_out, n_out.sda_drive} = {1'b1, w_nack, 1'b1};
            ST_MAL: {n_out.scl, n_out.sda_out, n_out.sda_drive} = {1'b0, w_nack, 1'b1};
            ST_SP1: {n_out.scl, n_out.sda_out, n_out.sda_drive} = 3'b001;
            ST_SP2: {n_out.scl, n_out.sda_out, n_out.sda_drive} = 3'b101;
            default: {n_out.scl, n_out.sda_out, n_out.sda_drive} = 3'b111;
        endcase
        n_out.busy_res = (n_step != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_IDLE;
            r_bit_cnt   <= '0;
            r_byte_idx  <= '0;
            r_shift     <= '0;
            r_load_ptr  <= '0;
            r_dev       <= '0;
            r_reg       <= '0;
            r_xfer_cnt  <= '0;
            r_reading   <= 1'b0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_step      <= n_step;
                r_bit_cnt   <= n_bit_cnt;
                r_byte_idx  <= n_byte_idx;
                r_shift     <= n_shift;
                r_load_ptr  <= n_load_ptr;
                r_dev       <= n_dev;
                r_reg       <= n_reg;
                r_xfer_cnt  <= n_xfer_cnt;
                r_reading   <= n_reading;
                r_failed    <= n_failed;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 16'(r_out);

    // a finished transaction never reports itself busy
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> !r_out.busy_res)
        else $error("done beat shows busy");

    // received bytes only show up in a read transaction
    a_rx_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.read_valid |-> r_reading)
        else $error("read_valid outside a read");

    // loads during a transaction leave the buffer pointer alone
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_cmd == CMD_LOAD && w_busy |=> $stable(r_load_ptr))
        else $error("load taken while busy");

    a_bit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt <= 4'(BITS_PER_BYTE))
        else $error("bit counter overran");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_load_ptr) <= BUFFER_BYTES)
        else $error("load pointer past buffer");

endmodule

`default_nettype wire
